@@ rtl/core/tdpt_pkg.sv @@
// Shared command and status types for the trial-division prime test.
package tdpt_pkg;

    // Smallest divisor tried, and the step between odd divisors after it.
    localparam int FIRST_DIVISOR = 2;
    localparam int ODD_STEP      = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture a new number and start the root search
        logic root_step;    // one digit of the floor square root
        logic div_start;    // begin a remainder pass with the current divisor
        logic div_step;     // one bit of the remainder pass
        logic next_div;     // advance to the next divisor
        logic set_verdict;  // store the verdict bit below
        logic verdict_val;  // verdict to store
        logic out_load;     // move the verdict into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_last;    // the step counter is on its final step
        logic rem_zero;     // the remainder being formed this cycle is zero
        logic below_two;    // number is negative, zero or one
        logic d_over;       // current divisor exceeds the floor square root
    } t_dp_status;

endpackage

@@ rtl/core/tdpt_datapath.sv @@
// Datapath: floor square root, bit-serial remainder unit and divisor counter.
module tdpt_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic [VALUE_BITS-1:0] i_number,
    input  tdpt_pkg::t_dp_cmd     i_cmd,
    output tdpt_pkg::t_dp_status  o_status,
    output logic                  o_is_prime
);
    import tdpt_pkg::*;

    // Magnitude bits of a nonnegative number, root bits and counter bits.
    localparam int NB = VALUE_BITS - 1;
    localparam int RB = (NB + 1) / 2;
    localparam int DW = RB + 1;
    localparam int CW = $clog2(NB);
    localparam logic [NB-1:0] BIT_INIT = NB'(1) << (2 * (RB - 1));

    logic          r_neg;
    logic [NB-1:0] r_num;
    logic [NB-1:0] r_rx, n_rx;
    logic [NB-1:0] r_res, n_res;
    logic [NB-1:0] r_bit;
    logic [NB:0]   w_trial;
    logic [NB-1:0] r_sh;
    logic [RB-1:0] r_rem, n_rem;
    logic [RB:0]   w_part;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_verdict;
    logic          r_out_bit;

    // One digit of the floor square root.
    always_comb begin
        w_trial = {1'b0, r_res} + {1'b0, r_bit};
        if ({1'b0, r_rx} >= w_trial) begin
            n_rx  = r_rx - w_trial[NB-1:0];
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rx  = r_rx;
            n_res = r_res >> 1;
        end
    end

    // One restoring step of the remainder: bring down a bit, subtract if it fits.
    always_comb begin
        w_part = {r_rem, r_sh[NB-1]};
        if (w_part >= r_div) begin
            n_rem = RB'(w_part - r_div);
        end else begin
            n_rem = w_part[RB-1:0];
        end
    end

    // Number capture, root search, remainder pass and divisor sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_number[VALUE_BITS-1];
            r_num <= i_number[NB-1:0];
            r_rx  <= i_number[NB-1:0];
            r_res <= '0;
            r_bit <= BIT_INIT;
            r_div <= DW'(FIRST_DIVISOR);
            r_cnt <= CW'(RB - 1);
        end
        if (i_cmd.root_step) begin
            r_rx  <= n_rx;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.div_start) begin
            r_sh  <= r_num;
            r_rem <= '0;
            r_cnt <= CW'(NB - 1);
        end
        if (i_cmd.div_step) begin
            r_sh  <= r_sh << 1;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.next_div) begin
            if (r_div == DW'(FIRST_DIVISOR)) begin
                r_div <= DW'(FIRST_DIVISOR + 1);
            end else begin
                r_div <= r_div + DW'(ODD_STEP);
            end
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict_val;
        end
        if (i_cmd.out_load) begin
            r_out_bit <= r_verdict;
        end
    end

    // Status toward the controller; the root sits in the low bits of r_res.
    always_comb begin
        o_status.step_last = (r_cnt == '0);
        o_status.rem_zero  = (n_rem == '0);
        o_status.below_two = r_neg || (r_num < NB'(FIRST_DIVISOR));
        o_status.d_over    = (r_div > {1'b0, r_res[RB-1:0]});
    end

    assign o_is_prime = r_out_bit;

endmodule

@@ rtl/core/tdpt_ctrl.sv @@
// Controller: sequences the root search and the trial divisions, owns the handshakes.
module tdpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  tdpt_pkg::t_dp_status i_status,
    output tdpt_pkg::t_dp_cmd    o_cmd
);
    import tdpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROOT  = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.below_two) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict_val = 1'b0;
                    n_state           = S_FIN;
                end else if (i_status.d_over) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict_val = 1'b1;
                    n_state           = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    if (i_status.rem_zero) begin
                        o_cmd.set_verdict = 1'b1;
                        o_cmd.verdict_val = 1'b0;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.next_div = 1'b1;
                        n_state        = S_CHECK;
                    end
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set when a verdict is loaded, cleared when it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// Top level of the trial-division prime test: controller plus datapath.
//
//  Channel  Direction  Payload (tdata, lowest bit up)
//  s_axis   in         number [VALUE_BITS-1:0], zero padding to whole bytes
//  m_axis   out        is_prime [0], zero padding to 8 bits
//
// One request is worked on at a time. After acceptance the root search runs,
// then each divisor (2, then odd values up to the root) gets a check step
// in S_CHECK and a pass of the bit-serial remainder unit; a prime tries
// about root/2 divisors. Reset clears the controller and the output valid.
// A stalled result sits in the output register while the next request is
// accepted and worked on.
module trial_division_prime_test #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // number
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // is_prime
    output logic [7:0]                          o_m_axis_tdata
);
    import tdpt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_is_prime;

    // Sequencer and handshakes.
    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Root, remainder and divisor arithmetic.
    tdpt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_number   (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_is_prime (w_is_prime)
    );

    assign o_m_axis_tdata = {7'b0, w_is_prime};

endmodule
